@@ design/hcsl_pkg.sv @@
// ----------------------------------------------------------------------------
// hcsl_pkg: shared definitions for the chunk-size line parser
// Phase and status codes, character constants, item and result types, and
// the byte classifiers used by the extension grammar.
// ----------------------------------------------------------------------------
package hcsl_pkg;

    localparam int SIZE_BITS = 64;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int CHUNK_W   = 64;
    localparam int PHASE_W   = 4;
    localparam int NIBBLE_W  = 4;

    // parser phases
    localparam logic [PHASE_W-1:0] PH_HEX        = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START      = 4'd1;
    localparam logic [PHASE_W-1:0] PH_NAME_WAIT  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_NAME       = 4'd3;
    localparam logic [PHASE_W-1:0] PH_NAME_AFTER = 4'd4;
    localparam logic [PHASE_W-1:0] PH_VAL_WAIT   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_VAL_TOKEN  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_QUOTED     = 4'd7;
    localparam logic [PHASE_W-1:0] PH_ESCAPE     = 4'd8;
    localparam logic [PHASE_W-1:0] PH_VAL_AFTER  = 4'd9;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NODIGIT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADEXT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

    // characters of the grammar
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_EQUALS = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_DEL    = 8'h7F;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              line_end;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CHUNK_W-1:0]  chunk_size;
    } t_result;

    typedef struct packed {
        logic               bad;
        logic [PHASE_W-1:0] phase;
    } t_ext;

    function automatic logic is_hex(input logic [BYTE_W-1:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
               (c >= "A" && c <= "F");
    endfunction

    function automatic logic [NIBBLE_W-1:0] hex_val(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        if (c >= "a" && c <= "f") begin
            v = c - "a" + 8'd10;
        end else if (c >= "A" && c <= "F") begin
            v = c - "A" + 8'd10;
        end else begin
            v = c - "0";
        end
        return v[NIBBLE_W-1:0];
    endfunction

    function automatic logic is_tchar(input logic [BYTE_W-1:0] c);
        logic r;
        r = (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
            (c >= "A" && c <= "Z");
        case (c)
            "!", "#", "$", "%", "&", "'", "*", "+", "-", ".", "^", "_", 8'h60,
            "|", "~": r = 1'b1;
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic is_bws(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    // next extension phase for one byte; bad set when the byte breaks the grammar
    function automatic t_ext ext_step(input logic [PHASE_W-1:0] ph,
                                      input logic [BYTE_W-1:0] c);
        t_ext r;
        r.bad   = 1'b0;
        r.phase = ph;
        case (ph)
            PH_START: begin
                if (is_bws(c))         r.phase = PH_START;
                else if (c == CH_SEMI) r.phase = PH_NAME_WAIT;
                else                   r.bad   = 1'b1;
            end
            PH_NAME_WAIT: begin
                if (is_bws(c))        r.phase = PH_NAME_WAIT;
                else if (is_tchar(c)) r.phase = PH_NAME;
                else                  r.bad   = 1'b1;
            end
            PH_NAME: begin
                if (is_tchar(c))         r.phase = PH_NAME;
                else if (is_bws(c))      r.phase = PH_NAME_AFTER;
                else if (c == CH_SEMI)   r.phase = PH_NAME_WAIT;
                else if (c == CH_EQUALS) r.phase = PH_VAL_WAIT;
                else                     r.bad   = 1'b1;
            end
            PH_NAME_AFTER: begin
                if (is_bws(c))           r.phase = PH_NAME_AFTER;
                else if (c == CH_SEMI)   r.phase = PH_NAME_WAIT;
                else if (c == CH_EQUALS) r.phase = PH_VAL_WAIT;
                else                     r.bad   = 1'b1;
            end
            PH_VAL_WAIT: begin
                if (is_bws(c))           r.phase = PH_VAL_WAIT;
                else if (c == CH_DQUOTE) r.phase = PH_QUOTED;
                else if (is_tchar(c))    r.phase = PH_VAL_TOKEN;
                else                     r.bad   = 1'b1;
            end
            PH_VAL_TOKEN: begin
                if (is_tchar(c))       r.phase = PH_VAL_TOKEN;
                else if (is_bws(c))    r.phase = PH_VAL_AFTER;
                else if (c == CH_SEMI) r.phase = PH_NAME_WAIT;
                else                   r.bad   = 1'b1;
            end
            PH_QUOTED: begin
                if (c == CH_DQUOTE)      r.phase = PH_VAL_AFTER;
                else if (c == CH_BSLASH) r.phase = PH_ESCAPE;
                else if (c == CH_DEL || (c < CH_SPACE && c != CH_TAB)) r.bad = 1'b1;
                else                     r.phase = PH_QUOTED;
            end
            PH_ESCAPE: begin
                if (c == CH_DEL || c < CH_SPACE) r.bad   = 1'b1;
                else                             r.phase = PH_QUOTED;
            end
            PH_VAL_AFTER: begin
                if (is_bws(c))         r.phase = PH_VAL_AFTER;
                else if (c == CH_SEMI) r.phase = PH_NAME_WAIT;
                else                   r.bad   = 1'b1;
            end
            default: r.bad = 1'b1;
        endcase
        return r;
    endfunction

    // phases in which the line may end cleanly
    function automatic logic end_ok(input logic [PHASE_W-1:0] ph);
        return (ph == PH_HEX) || (ph == PH_START) || (ph == PH_NAME) ||
               (ph == PH_NAME_AFTER) || (ph == PH_VAL_TOKEN) || (ph == PH_VAL_AFTER);
    endfunction

endpackage

@@ design/hcsl_in_if.sv @@
// ----------------------------------------------------------------------------
// hcsl_in_if: byte request channel
// Valid/ready channel carrying one line byte or the end-of-line marker.
// ----------------------------------------------------------------------------
interface hcsl_in_if;
    import hcsl_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              line_end;

    modport source (output valid, output data_byte, output line_end, input ready);
    modport sink   (input valid, input data_byte, input line_end, output ready);
endinterface

@@ design/hcsl_out_if.sv @@
// ----------------------------------------------------------------------------
// hcsl_out_if: result request channel
// Valid/ready channel carrying the status and chunk size of one line.
// ----------------------------------------------------------------------------
interface hcsl_out_if;
    import hcsl_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CHUNK_W-1:0]  chunk_size;

    modport source (output valid, output status, output chunk_size, input ready);
    modport sink   (input valid, input status, input chunk_size, output ready);
endinterface

@@ design/http_chunk_size_line_parser_core.sv @@
// ----------------------------------------------------------------------------
// http_chunk_size_line_parser_core: HTTP/1.1 chunk-size line parser
// Send the bytes of one chunk-size line (no CR LF) on i_req, one request per
// byte with line_end low, then one request with line_end high. The block
// returns one result on o_rsp for each line: status (0 ok, 1 no hex digits,
// 2 bad extension, 3 size overflow) and chunk_size, zero on any error.
// Byte requests give no result.
// Throughput: one request per cycle, sustained while no line end waits on a
// held result; the per-byte state update is a single pass of logic between
// the input and result registers. A line's result is registered when its
// end-of-line request moves on from the input register.
// Reset: i_rst_n low on a clock edge empties both registers and returns the
// parser to the start of a line.
// Stall: while o_rsp is held, i_req keeps taking requests until the input
// register is full; bytes still advance the line state as long as no new
// result has to enter the occupied result register.
// ----------------------------------------------------------------------------
module http_chunk_size_line_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hcsl_in_if.sink    i_req,
    hcsl_out_if.source o_rsp
);
    import hcsl_pkg::*;

    logic    w_in_valid;
    t_item   w_item;
    logic    w_out_free;
    logic    w_advance;
    logic    w_fire;
    logic    w_res_valid;
    t_result w_res;

    // a byte moves on freely; a line end needs room in the result register
    assign w_advance = w_out_free || (w_in_valid && !w_item.line_end);
    assign w_fire    = w_in_valid && w_advance;

    hcsl_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_item    (w_item)
    );

    hcsl_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    hcsl_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_res_valid),
        .i_res     (w_res),
        .o_advance (w_out_free),
        .o_rsp     (o_rsp)
    );
endmodule

@@ design/hcsl_in_stage.sv @@
// ----------------------------------------------------------------------------
// hcsl_in_stage: input register
// Captures one request per cycle and holds it until the parser advances.
// ----------------------------------------------------------------------------
module hcsl_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hcsl_in_if.sink       i_req,
    input  logic          i_advance,
    output logic          o_valid,
    output hcsl_pkg::t_item o_item
);
    import hcsl_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  w_take;

    // accept when empty or when the held request moves on this cycle
    assign i_req.ready = !r_valid || i_advance;
    assign w_take      = i_req.valid && i_req.ready;

    // hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // capture payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.data_byte <= i_req.data_byte;
            r_item.line_end  <= i_req.line_end;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

@@ design/hcsl_parse.sv @@
// ----------------------------------------------------------------------------
// hcsl_parse: line state and per-byte update
// Gathers hex digits, walks the extension grammar and forms the result on
// the end-of-line marker, then returns to the start-of-line state.
// ----------------------------------------------------------------------------
module hcsl_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  hcsl_pkg::t_item   i_item,
    output logic              o_res_valid,
    output hcsl_pkg::t_result o_res
);
    import hcsl_pkg::*;

    logic [PHASE_W-1:0]   r_phase,  n_phase;
    logic [SIZE_BITS-1:0] r_accum,  n_accum;
    logic                 r_digit,  n_digit;
    logic [STATUS_W-1:0]  r_err,    n_err;

    logic [BYTE_W-1:0]    w_c;
    t_ext                 w_ext;
    logic [STATUS_W-1:0]  w_status;

    assign w_c   = i_item.data_byte;
    // a non-digit in the hex phase is parsed as the first extension byte
    assign w_ext = ext_step((r_phase == PH_HEX) ? PH_START : r_phase, w_c);

    // status of the line as it stands
    always_comb begin
        w_status = r_err;
        if (r_err == ST_OK) begin
            if (!r_digit) begin
                w_status = ST_NODIGIT;
            end else if (!end_ok(r_phase)) begin
                w_status = ST_BADEXT;
            end
        end
    end

    // next state for one byte or line end
    always_comb begin
        n_phase = r_phase;
        n_accum = r_accum;
        n_digit = r_digit;
        n_err   = r_err;
        if (i_item.line_end) begin
            n_phase = PH_HEX;
            n_accum = '0;
            n_digit = 1'b0;
            n_err   = ST_OK;
        end else if (r_err == ST_OK) begin
            if (r_phase == PH_HEX && is_hex(w_c)) begin
                if (|r_accum[SIZE_BITS-1 -: NIBBLE_W]) begin
                    n_err = ST_OVERFLOW;
                end else begin
                    n_accum = {r_accum[SIZE_BITS-NIBBLE_W-1:0], hex_val(w_c)};
                    n_digit = 1'b1;
                end
            end else if (r_phase == PH_HEX && !r_digit) begin
                n_err = ST_NODIGIT;
            end else if (w_ext.bad) begin
                n_err = ST_BADEXT;
            end else begin
                n_phase = w_ext.phase;
            end
        end
    end

    // advance line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEX;
            r_accum <= '0;
            r_digit <= 1'b0;
            r_err   <= ST_OK;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_accum <= n_accum;
            r_digit <= n_digit;
            r_err   <= n_err;
        end
    end

    assign o_res_valid      = i_fire && i_item.line_end;
    assign o_res.status     = w_status;
    assign o_res.chunk_size = (w_status == ST_OK) ? CHUNK_W'(r_accum) : '0;
endmodule

@@ design/hcsl_out_stage.sv @@
// ----------------------------------------------------------------------------
// hcsl_out_stage: result register
// Holds one result until the receiver takes it and reports when the
// pipeline may advance.
// ----------------------------------------------------------------------------
module hcsl_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  hcsl_pkg::t_result i_res,
    output logic              o_advance,
    hcsl_out_if.source        o_rsp
);
    import hcsl_pkg::*;

    logic    r_valid;
    t_result r_res;

    // advance while the register is empty or being drained
    assign o_advance = !r_valid || o_rsp.ready;

    // hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load;
        end
    end

    // capture result
    always_ff @(posedge i_clk) begin
        if (o_advance && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_rsp.valid      = r_valid;
    assign o_rsp.status     = r_res.status;
    assign o_rsp.chunk_size = r_res.chunk_size;
endmodule

@@ tb/http_chunk_size_line_parser_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunk_size_line_parser_core_test: self-checking bench for the parser
// Feeds chunk-size lines byte by byte through the request channel. Each line
// is a short directed case, a well-formed line with random content, a broken
// line or noise. The bench models the size and extension grammar itself,
// queues the status and size due for each line and checks every result.
// Random gaps and stalls are applied on both channels, with one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module http_chunk_size_line_parser_core_test;
    import hcsl_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_ITEMS = 900;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam logic [CHUNK_W-1:0] SIZE_MAX =
        (SIZE_BITS >= CHUNK_W) ? {CHUNK_W{1'b1}} : ((64'd1 << SIZE_BITS) - 64'd1);

    typedef struct {
        t_item       it;
        int unsigned gap;
    } t_pending;

    logic i_clk;
    logic i_rst_n;

    hcsl_in_if  req_ch ();
    hcsl_out_if rsp_ch ();

    http_chunk_size_line_parser_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // stimulus and scoreboard
    t_pending    pending_reqs[$];
    t_result     expected_lines[$];
    logic [7:0]  line_buf[$];
    int unsigned n_queued;
    int unsigned n_accepted;
    int unsigned n_lines;
    int unsigned n_errors;
    int unsigned status_seen[4];
    int unsigned cycles;
    int unsigned gap_style;
    logic        req_fire;
    logic        hold_off;

    // predicted parser state
    logic [PHASE_W-1:0]  pr_phase;
    logic [CHUNK_W-1:0]  pr_size;
    logic                pr_digit;
    logic [STATUS_W-1:0] pr_err;

    // driver state
    t_pending    next_req;
    logic        have_next;
    int unsigned gap_left;

    // receiver state
    int unsigned stall_left;
    int unsigned calm_left;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ---------------------------------------------------------------- model

    function automatic logic blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic logic token_char(input logic [7:0] c);
        logic alnum;
        alnum = (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        case (c)
            "!", "#", "$", "%", "&", "'", "*", "+", "-", ".", "^", "_", 8'h60, "|", "~":
                return 1'b1;
            default:
                return alnum;
        endcase
    endfunction

    function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] nib);
        logic [7:0] d;
        d = 8'd0;
        nib = 4'd0;
        if (c >= "0" && c <= "9") begin
            d = c - "0";
        end else if (c >= "a" && c <= "f") begin
            d = c - "a" + 8'd10;
        end else if (c >= "A" && c <= "F") begin
            d = c - "A" + 8'd10;
        end else begin
            return 1'b0;
        end
        nib = d[3:0];
        return 1'b1;
    endfunction

    // one step of the extension grammar; bad marks a byte that breaks it
    function automatic logic [PHASE_W-1:0] ext_advance(input logic [PHASE_W-1:0] ph,
                                                       input logic [7:0] c,
                                                       output logic bad);
        bad = 1'b0;
        case (ph)
            PH_START: begin
                if (blank(c)) return PH_START;
                if (c == CH_SEMI) return PH_NAME_WAIT;
            end
            PH_NAME_WAIT: begin
                if (blank(c)) return PH_NAME_WAIT;
                if (token_char(c)) return PH_NAME;
            end
            PH_NAME: begin
                if (token_char(c)) return PH_NAME;
                if (blank(c)) return PH_NAME_AFTER;
                if (c == CH_SEMI) return PH_NAME_WAIT;
                if (c == CH_EQUALS) return PH_VAL_WAIT;
            end
            PH_NAME_AFTER: begin
                if (blank(c)) return PH_NAME_AFTER;
                if (c == CH_SEMI) return PH_NAME_WAIT;
                if (c == CH_EQUALS) return PH_VAL_WAIT;
            end
            PH_VAL_WAIT: begin
                if (blank(c)) return PH_VAL_WAIT;
                if (c == CH_DQUOTE) return PH_QUOTED;
                if (token_char(c)) return PH_VAL_TOKEN;
            end
            PH_VAL_TOKEN: begin
                if (token_char(c)) return PH_VAL_TOKEN;
                if (blank(c)) return PH_VAL_AFTER;
                if (c == CH_SEMI) return PH_NAME_WAIT;
            end
            PH_QUOTED: begin
                if (c == CH_DQUOTE) return PH_VAL_AFTER;
                if (c == CH_BSLASH) return PH_ESCAPE;
                if (!(c == CH_DEL || (c < CH_SPACE && c != CH_TAB))) return PH_QUOTED;
            end
            PH_ESCAPE: begin
                if (!(c == CH_DEL || c < CH_SPACE)) return PH_QUOTED;
            end
            PH_VAL_AFTER: begin
                if (blank(c)) return PH_VAL_AFTER;
                if (c == CH_SEMI) return PH_NAME_WAIT;
            end
            default: ;
        endcase
        bad = 1'b1;
        return ph;
    endfunction

    function automatic logic clean_end(input logic [PHASE_W-1:0] ph);
        return ph == PH_HEX || ph == PH_START || ph == PH_NAME ||
               ph == PH_NAME_AFTER || ph == PH_VAL_TOKEN || ph == PH_VAL_AFTER;
    endfunction

    task automatic clear_line_state();
        pr_phase = PH_HEX;
        pr_size  = '0;
        pr_digit = 1'b0;
        pr_err   = ST_OK;
    endtask

    // advance the predicted line state by one accepted request
    task automatic parse_request(input t_item it);
        logic [STATUS_W-1:0] st;
        t_result             r;
        logic [3:0]          nib;
        logic [PHASE_W-1:0]  nx;
        logic                bad;
        logic                to_ext;
        if (it.line_end) begin
            st = pr_err;
            if (st == ST_OK) begin
                if (!pr_digit) st = ST_NODIGIT;
                else if (!clean_end(pr_phase)) st = ST_BADEXT;
            end
            r.status     = st;
            r.chunk_size = (st == ST_OK) ? (pr_size & SIZE_MAX) : '0;
            expected_lines.push_back(r);
            status_seen[st]++;
            clear_line_state();
        end else if (pr_err == ST_OK) begin
            to_ext = 1'b1;
            if (pr_phase == PH_HEX) begin
                if (hex_digit(it.data_byte, nib)) begin
                    if (pr_size > (SIZE_MAX >> 4)) begin
                        pr_err = ST_OVERFLOW;
                    end else begin
                        pr_size  = ((pr_size << 4) | CHUNK_W'(nib)) & SIZE_MAX;
                        pr_digit = 1'b1;
                    end
                    to_ext = 1'b0;
                end else if (!pr_digit) begin
                    pr_err = ST_NODIGIT;
                    to_ext = 1'b0;
                end else begin
                    pr_phase = PH_START;
                end
            end
            if (to_ext) begin
                nx = ext_advance(pr_phase, it.data_byte, bad);
                if (bad) pr_err = ST_BADEXT;
                else pr_phase = nx;
            end
        end
    endtask

    // ------------------------------------------------------------ stimulus

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int unsigned req_gap();
        if (gap_style == 0) return 0;
        if ($urandom_range(0, 99) < 70) return 0;
        return pick_gap();
    endfunction

    task automatic push_req(input logic [7:0] b, input logic last);
        t_pending p;
        p.it.data_byte = b;
        p.it.line_end  = last;
        p.gap          = req_gap();
        pending_reqs.push_back(p);
        n_queued++;
    endtask

    // queue the buffered line followed by its end marker
    task automatic push_line();
        foreach (line_buf[i]) push_req(line_buf[i], 1'b0);
        push_req(8'($urandom_range(0, 255)), 1'b1);
        line_buf.delete();
    endtask

    function automatic logic [7:0] pick_tchar();
        string s;
        s = "!#$%&'*+-.^_|~0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
        if ($urandom_range(0, 99) < 5) return 8'h60;
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic add_blanks();
        int unsigned n;
        n = ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 2);
        repeat (n) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endtask

    task automatic add_token();
        repeat ($urandom_range(1, 5)) line_buf.push_back(pick_tchar());
    endtask

    // quoted value with printable, high and escaped bytes
    task automatic add_quoted();
        int unsigned r;
        logic [7:0]  c;
        line_buf.push_back(CH_DQUOTE);
        repeat ($urandom_range(0, 5)) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                line_buf.push_back(CH_BSLASH);
                c = 8'($urandom_range(8'h20, 8'hFF));
                line_buf.push_back(c == CH_DEL ? CH_DQUOTE : c);
            end else if (r < 30) begin
                line_buf.push_back(8'($urandom_range(8'h80, 8'hFF)));
            end else if (r < 35) begin
                line_buf.push_back(CH_TAB);
            end else begin
                c = 8'($urandom_range(8'h20, 8'h7E));
                line_buf.push_back((c == CH_DQUOTE || c == CH_BSLASH) ? "x" : c);
            end
        end
        line_buf.push_back(CH_DQUOTE);
    endtask

    task automatic add_size();
        string       hx;
        int unsigned r;
        int unsigned n;
        hx = "0123456789abcdefABCDEF";
        r = $urandom_range(0, 99);
        if (r < 70) n = $urandom_range(1, 4);
        else if (r < 85) n = $urandom_range(5, 15);
        else if (r < 93) n = 16;
        else n = $urandom_range(17, 18);
        if ($urandom_range(0, 99) < 20) begin
            repeat (n) line_buf.push_back($urandom_range(0, 1) ? "f" : "F");
        end else begin
            repeat (n) line_buf.push_back(hx[$urandom_range(0, hx.len() - 1)]);
        end
    endtask

    task automatic build_good_line();
        add_size();
        repeat ($urandom_range(0, 3)) begin
            add_blanks();
            line_buf.push_back(CH_SEMI);
            add_blanks();
            add_token();
            if ($urandom_range(0, 99) < 60) begin
                add_blanks();
                line_buf.push_back(CH_EQUALS);
                add_blanks();
                if ($urandom_range(0, 1)) add_quoted();
                else add_token();
            end
        end
        add_blanks();
    endtask

    // -------------------------------------------------------------- driver

    // offer the next queued request once the previous one has gone
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_fire) begin
            if (!have_next && pending_reqs.size() != 0) begin
                next_req  = pending_reqs.pop_front();
                gap_left  = next_req.gap;
                have_next = 1'b1;
            end
            if (have_next && gap_left == 0) begin
                req_ch.valid     <= 1'b1;
                req_ch.data_byte <= next_req.it.data_byte;
                req_ch.line_end  <= next_req.it.line_end;
                have_next = 1'b0;
            end else begin
                if (gap_left != 0) gap_left--;
                req_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, calm stretches, and the long hold-off
    always @(negedge i_clk) begin
        logic        rdy;
        int unsigned r;
        rdy = 1'b1;
        if (!i_rst_n || hold_off) begin
            rdy = 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            rdy = 1'b0;
        end else if (calm_left != 0) begin
            calm_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                calm_left = $urandom_range(40, 160);
            end else if (r < 25) begin
                stall_left = pick_gap() - 1;
                rdy = 1'b0;
            end
        end
        rsp_ch.ready <= rdy;
    end

    // ------------------------------------------------------------- monitor

    // check results first, then fold in the request taken at this edge
    always @(posedge i_clk) begin
        t_result     exp_r;
        t_item       it;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                n_lines++;
                if (expected_lines.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result, status %0d size %h", $time,
                             rsp_ch.status, rsp_ch.chunk_size);
                end else begin
                    exp_r = expected_lines.pop_front();
                    if (rsp_ch.status !== exp_r.status) begin
                        n_errors++;
                        $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                                 exp_r.status, rsp_ch.status);
                    end
                    if (rsp_ch.chunk_size !== exp_r.chunk_size) begin
                        n_errors++;
                        $display("%0t: chunk_size mismatch, expected %h, actual %h", $time,
                                 exp_r.chunk_size, rsp_ch.chunk_size);
                    end
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                it.data_byte = req_ch.data_byte;
                it.line_end  = req_ch.line_end;
                n_accepted++;
                parse_request(it);
            end
        end
        req_fire <= i_rst_n && req_ch.valid && req_ch.ready;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, expected_lines.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // hold the receiver off long enough for the block to fill and stall
    initial begin
        hold_off = 1'b0;
        wait (n_accepted >= 300);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // ---------------------------------------------------------------- main

    initial begin
        int unsigned r;
        int unsigned cut;
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.data_byte = '0;
        req_ch.line_end  = 1'b0;
        rsp_ch.ready     = 1'b0;
        req_fire   = 1'b0;
        have_next  = 1'b0;
        gap_left   = 0;
        stall_left = 0;
        calm_left  = 0;
        n_queued   = 0;
        n_accepted = 0;
        n_lines    = 0;
        n_errors   = 0;
        cycles     = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        clear_line_state();

        // directed: empty line
        gap_style = 1;
        push_line();
        // first byte not a hex digit, later bytes ignored
        line_buf = '{8'hFF, 8'h00};
        push_line();
        // zero size
        line_buf = '{"0"};
        push_line();
        // quoted value with a high byte and an escaped high byte
        line_buf = '{"f", CH_SEMI, "a", CH_EQUALS, CH_DQUOTE, 8'h80, CH_BSLASH, 8'hFF,
                     CH_DQUOTE};
        push_line();
        // line ends while waiting for a name
        line_buf = '{"1", CH_SEMI};
        push_line();
        // hex digit after the size counts as an extension byte
        line_buf = '{"1", CH_SPACE, "F"};
        push_line();

        // random lines: mostly well formed, the rest broken lines or noise
        while (n_queued < RANDOM_ITEMS + 23) begin
            gap_style = ($urandom_range(0, 99) < 15) ? 0 : 1;
            r = $urandom_range(0, 99);
            if (r < 60) begin
                build_good_line();
            end else if (r < 70) begin
                build_good_line();
                cut = $urandom_range(0, line_buf.size());
                while (line_buf.size() > cut) void'(line_buf.pop_back());
            end else if (r < 85) begin
                build_good_line();
                line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
            end else begin
                repeat ($urandom_range(0, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
            end
            push_line();
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_accepted == n_queued);
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d byte and end requests, checked %0d line results", n_accepted, n_lines);
        $display("Status mix: ok %0d, no digits %0d, bad extension %0d, overflow %0d",
                 status_seen[ST_OK], status_seen[ST_NODIGIT], status_seen[ST_BADEXT],
                 status_seen[ST_OVERFLOW]);
        if (n_errors == 0 && expected_lines.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
